>>> sv/oahi_pkg.sv
// ----------------------------------------------------------------------------
// oahi_pkg
// Shared widths, codes and state types of the open-addressed hash insert unit.
// ----------------------------------------------------------------------------
package oahi_pkg;

   // Payload widths of the request and response channels.
   localparam int KEY_W    = 16;
   localparam int SLOT_W   = 10;
   localparam int PROBES_W = 10;
   localparam int TOTAL_W  = 20;

   // Saturation limits of the reported counts.
   localparam logic [PROBES_W-1:0] PROBES_MAX = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

   // Register file: one 32-bit word per register, byte addressed.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_PROBE_MODE = '0;

   // Slot memory word: occupied flag on top of the stored key.
   localparam int RAM_W = KEY_W + 1;

   typedef enum logic {
      MODE_DOUBLE    = 1'b0,
      MODE_QUADRATIC = 1'b1
   } probe_mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RED_Q,
      ST_RED_M,
      ST_RED_F,
      ST_ISSUE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Which value the shared modulo reduction is working on.
   typedef enum logic [1:0] {
      PH_HOME,
      PH_STEP_KEY,
      PH_STEP_TABLE
   } phase_type;

endpackage

>>> sv/oahi_req_if.sv
// ----------------------------------------------------------------------------
// oahi_req_if
// Request channel: one key per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface oahi_req_if;
   logic                       valid;
   logic                       ready;
   logic [oahi_pkg::KEY_W-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

>>> sv/oahi_rsp_if.sv
// ----------------------------------------------------------------------------
// oahi_rsp_if
// Response channel: insert outcome per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface oahi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oahi_pkg::SLOT_W-1:0]   slot;
   logic [oahi_pkg::PROBES_W-1:0] probes;
   logic                          stored;
   logic [oahi_pkg::TOTAL_W-1:0]  total_probes;

   modport source (output valid, output slot, output probes, output stored,
                   output total_probes, input ready);
   modport sink   (input valid, input slot, input probes, input stored,
                   input total_probes, output ready);
endinterface

>>> sv/oahi_ram.sv
// ----------------------------------------------------------------------------
// oahi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oahi_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1009
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/open_addressing_hash_insert.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// Inserts keys into an open-addressed table using double hashing or
// quadratic probing, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req_ch carries one key. The key lands in the first free
// slot of the probe sequence that starts at its home slot (key mod table
// size), and one response on rsp_ch reports the slot, the number of probes,
// whether the key was stored and the running probe total since reset.
// The probe scheme is chosen by the probe_mode register on the csr_ port,
// which the user must write only while no request is in flight; the block
// itself does not enforce this. A request is taken in the idle state, then
// the shared multiplier reduces the key to its home slot; in double hashing
// mode it also reduces the key modulo the step prime to form the step, and
// that step modulo the table size when the step prime is not below it.
// Each probe reads the slot memory in ST_ISSUE and checks the returned flag
// in ST_CHECK. The slot memory read port sets the pace.
// After reset the block sweeps the whole slot memory to mark
// every slot free; req_ch.ready stays low meanwhile, while register writes
// are taken. A stalled response sits in the output register; the block
// keeps working on the next request and only waits before handing it over.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert #(
   parameter int TABLE_SIZE = 1009,
   parameter int STEP_PRIME = 19
) (
   input  logic                              clock,
   input  logic                              reset,
   oahi_req_if.sink                          req_ch,
   oahi_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [oahi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [oahi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [oahi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import oahi_pkg::*;

   // Slot index and probe count widths follow the table size.
   localparam int SW     = $clog2(TABLE_SIZE);
   localparam int SW1    = SW + 1;
   localparam int CW     = $clog2(TABLE_SIZE + 1);
   localparam int SWS    = SW + SLOT_W;
   localparam int CWP    = CW + PROBES_W;
   localparam int TSUM_W = TOTAL_W + 1;

   localparam logic [SW:0]      TABLE_MOD   = SW1'(TABLE_SIZE);
   localparam logic [SW-1:0]    LAST_SLOT   = SW'(TABLE_SIZE - 1);
   localparam logic [SW-1:0]    TWO_MOD     = SW'(2 % TABLE_SIZE);
   localparam logic [SW-1:0]    ONE_SLOT    = SW'(1 % TABLE_SIZE);
   localparam logic [CW-1:0]    TABLE_COUNT = CW'(TABLE_SIZE);
   localparam logic [KEY_W-1:0] MOD_T       = KEY_W'(TABLE_SIZE);
   localparam logic [KEY_W-1:0] MOD_P       = KEY_W'(STEP_PRIME);

   // Reciprocals for division by multiplication. The quotient estimate is
   // at most one below the true quotient for any 16-bit value, so a single
   // compare and subtract finishes the remainder.
   localparam logic [31:0] RECIP_T = 32'((64'd1 << 32) / TABLE_SIZE);
   localparam logic [31:0] RECIP_P = 32'((64'd1 << 32) / STEP_PRIME);

   // When the step prime is below the table size the step is already a
   // valid offset and needs no second reduction.
   localparam bit STEP_FITS = (STEP_PRIME < TABLE_SIZE);

   localparam logic [PROBES_W-1:0] PROBES_FULL =
      (TABLE_SIZE > int'(PROBES_MAX)) ? PROBES_MAX : PROBES_W'(TABLE_SIZE);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   probe_mode_type       probe_mode_ff, probe_mode_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [KEY_W-1:0]     x_ff, x_in;
   logic [47:0]          prod_ff, prod_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SW-1:0]        slot_nx_ff, slot_nx_in;
   logic [SW-1:0]        inc_ff, inc_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        clr_ff, clr_in;
   logic [SW-1:0]        res_slot_ff, res_slot_in;
   logic [CW-1:0]        res_count_ff, res_count_in;
   logic                 res_stored_ff, res_stored_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [PROBES_W-1:0]  rsp_probes_ff, rsp_probes_in;
   logic                 rsp_stored_ff, rsp_stored_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   // ------------------------------------------------------------------
   // Shared units and helper signals
   // ------------------------------------------------------------------
   logic [31:0]          mul_a;
   logic [15:0]          mul_b;
   logic [KEY_W-1:0]     red_mod;
   logic [KEY_W-1:0]     rem_raw;
   logic [KEY_W-1:0]     rem;
   logic [KEY_W-1:0]     step_val;
   logic [SW-1:0]        add_a;
   logic [SW-1:0]        add_b;
   logic [SW:0]          add_sum;
   logic [SW-1:0]        add_res;
   logic                 probe_start;
   logic                 slot_busy;
   logic [CW-1:0]        count_next;
   logic                 last_probe;
   logic [TSUM_W-1:0]    total_sum;
   logic                 out_free;
   logic [SWS-1:0]       slot_wide;
   logic [CWP-1:0]       count_wide;
   logic                 csr_write;
   logic [CSR_ADDR_W-3:0] csr_word;

   // Slot memory port signals.
   logic                 ram_wr_en;
   logic [SW-1:0]        ram_wr_addr;
   logic [RAM_W-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [SW-1:0]        ram_rd_addr;
   logic [RAM_W-1:0]     ram_rd_data;

   oahi_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Configuration port. Only bit 0 of the written word is kept.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_word   = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      probe_mode_in = probe_mode_ff;
      if (csr_write && (csr_word == REG_PROBE_MODE)) begin
         probe_mode_in = probe_mode_type'(csr_pwdata[0]);
      end
   end

   assign csr_prdata = (csr_word == REG_PROBE_MODE) ? CSR_DATA_W'(probe_mode_ff) : '0;

   // ------------------------------------------------------------------
   // Shared arithmetic
   // ------------------------------------------------------------------
   // Remainder step: x minus the quotient estimate times the modulus,
   // followed by one correction.
   always_comb begin
      red_mod  = (phase_ff == PH_STEP_KEY) ? MOD_P : MOD_T;
      rem_raw  = x_ff - prod_ff[15:0];
      rem      = (rem_raw >= red_mod) ? (rem_raw - red_mod) : rem_raw;
      step_val = MOD_P - rem;
   end

   // The one multiplier: key (or step) times a reciprocal in ST_RED_Q,
   // quotient times the modulus in ST_RED_M.
   always_comb begin
      if (state_ff == ST_RED_M) begin
         mul_a = {16'd0, prod_ff[47:32]};
         mul_b = red_mod;
      end else begin
         mul_a = (phase_ff == PH_STEP_KEY) ? RECIP_P : RECIP_T;
         mul_b = x_ff;
      end
   end

   assign prod_in = 48'(mul_a) * 48'(mul_b);

   // Modular adder: next slot while the read is issued, next quadratic
   // increment while the read data is checked. Both operands stay below
   // the table size, so one subtraction brings the sum back into range.
   always_comb begin
      if (state_ff == ST_CHECK) begin
         add_a = inc_ff;
         add_b = TWO_MOD;
      end else begin
         add_a = slot_ff;
         add_b = inc_ff;
      end
      add_sum = {1'b0, add_a} + {1'b0, add_b};
      add_res = (add_sum >= TABLE_MOD) ? SW'(add_sum - TABLE_MOD) : add_sum[SW-1:0];
   end

   // Probing starts once the home slot and, in double hashing mode, the
   // step are known.
   always_comb begin
      priority case (phase_ff)
         PH_HOME:       probe_start = (probe_mode_ff == MODE_QUADRATIC);
         PH_STEP_KEY:   probe_start = STEP_FITS;
         PH_STEP_TABLE: probe_start = 1'b1;
         default:       probe_start = 1'b1;
      endcase
   end

   assign slot_busy  = ram_rd_data[RAM_W-1];
   assign count_next = idx_ff + CW'(1);
   assign last_probe = (count_next == TABLE_COUNT);
   assign total_sum  = {1'b0, total_ff} + TSUM_W'(count_next);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_ff};
   assign count_wide = {{PROBES_W{1'b0}}, res_count_ff};

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_RED_Q;
            end
         end
         ST_RED_Q: state_in = ST_RED_M;
         ST_RED_M: state_in = ST_RED_F;
         ST_RED_F: begin
            state_in = probe_start ? ST_ISSUE : ST_RED_Q;
         end
         ST_ISSUE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (!slot_busy || last_probe) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: datapath and memory control
   // ------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      key_in        = key_ff;
      x_in          = x_ff;
      slot_in       = slot_ff;
      slot_nx_in    = slot_nx_ff;
      inc_in        = inc_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      res_stored_in = res_stored_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probes_in = rsp_probes_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_total_in  = rsp_total_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = {1'b1, key_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = slot_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Mark one slot free per cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + SW'(1);
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               key_in   = req_ch.key;
               x_in     = req_ch.key;
               phase_in = PH_HOME;
               idx_in   = '0;
            end
         end
         ST_RED_Q, ST_RED_M: begin
         end
         ST_RED_F: begin
            priority case (phase_ff)
               PH_HOME: begin
                  slot_in  = rem[SW-1:0];
                  inc_in   = ONE_SLOT;
                  phase_in = PH_STEP_KEY;
               end
               PH_STEP_KEY: begin
                  inc_in   = step_val[SW-1:0];
                  x_in     = step_val;
                  phase_in = PH_STEP_TABLE;
               end
               default: begin
                  inc_in = rem[SW-1:0];
               end
            endcase
         end
         ST_ISSUE: begin
            ram_rd_en  = 1'b1;
            slot_nx_in = add_res;
         end
         ST_CHECK: begin
            if (!slot_busy || last_probe) begin
               // Free slot found, or every probe has been spent.
               ram_wr_en     = !slot_busy;
               res_slot_in   = slot_ff;
               res_stored_in = !slot_busy;
               res_count_in  = count_next;
               total_in      = (total_sum > TSUM_W'(TOTAL_MAX)) ?
                               TOTAL_MAX : total_sum[TOTAL_W-1:0];
            end else begin
               slot_in = slot_nx_ff;
               idx_in  = count_next;
               if (probe_mode_ff == MODE_QUADRATIC) begin
                  inc_in = add_res;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_stored_ff ? slot_wide[SLOT_W-1:0] : '0;
               rsp_probes_in = (count_wide > CWP'(PROBES_MAX)) ?
                               PROBES_MAX : count_wide[PROBES_W-1:0];
               rsp_stored_in = res_stored_ff;
               rsp_total_in  = total_ff;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Register updates
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         probe_mode_ff <= MODE_DOUBLE;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         probe_mode_ff <= probe_mode_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      key_ff        <= key_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      slot_ff       <= slot_in;
      slot_nx_ff    <= slot_nx_in;
      inc_ff        <= inc_in;
      idx_ff        <= idx_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      res_stored_ff <= res_stored_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // ------------------------------------------------------------------
   // Channel outputs
   // ------------------------------------------------------------------
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.probes       = rsp_probes_ff;
   assign rsp_ch.stored       = rsp_stored_ff;
   assign rsp_ch.total_probes = rsp_total_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // No request is taken right after reset, while the slot memory is still being cleared.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ch.ready)
      else $error("request accepted right after reset");

   // A key that was not stored used every probe and reports slot zero.
   a_exhausted_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stored_ff) |->
         (rsp_slot_ff == '0) && (rsp_probes_ff == PROBES_FULL))
      else $error("exhausted insert reported wrong slot or probe count");

   // The running total never goes down.
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("running probe total decreased");

   // The probe index stays inside the table while probing.
   a_probe_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (idx_ff < TABLE_COUNT))
      else $error("probe index ran past the table size");

endmodule
